@@ rtl/fscc_pkg.sv @@
// ----------------------------------------------------------------------------
// fscc_pkg
// Shared constants, function codes and controller/datapath types for the
// sector buffer cache.
// ----------------------------------------------------------------------------
package fscc_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int FUNC_W      = 2;
  localparam int SECTOR_W    = 32;
  localparam int SLOT_W      = 3;
  localparam int FCNT_W      = $clog2(MAX_RESULTS);

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  typedef struct packed {
    logic ld_item;
    logic idx_clr;
    logic idx_inc;
    logic sweep_step;
    logic fcnt_clr;
    logic emit_hit;
    logic emit_miss;
    logic emit_flush;
    logic emit_idle;
  } fscc_cmd_t;

  typedef struct packed {
    logic hit_match;
    logic idx_last;
    logic ref_at_hand;
    logic vd_at_idx;
    logic flush_last;
    logic fcnt_zero;
    logic out_free;
  } fscc_sts_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                hit;
    logic                write_back;
    logic [SECTOR_W-1:0] write_sector;
    logic [SECTOR_W-1:0] mirror_sector;
    logic                fetch;
    logic                last;
  } fscc_result_t;

endpackage

@@ rtl/fscc_if.sv @@
// ----------------------------------------------------------------------------
// fscc_if
// Valid/ready channels: access requests in, cache results out.
// ----------------------------------------------------------------------------
interface fscc_in_if;
  import fscc_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SECTOR_W-1:0] sector;

  modport source (output valid, output func, output sector, input ready);
  modport sink   (input valid, input func, input sector, output ready);
endinterface

interface fscc_out_if;
  import fscc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic                hit;
  logic                write_back;
  logic [SECTOR_W-1:0] write_sector;
  logic [SECTOR_W-1:0] mirror_sector;
  logic                fetch;
  logic                last;

  modport source (output valid, output slot, output hit, output write_back,
                  output write_sector, output mirror_sector, output fetch,
                  output last, input ready);
  modport sink   (input valid, input slot, input hit, input write_back,
                  input write_sector, input mirror_sector, input fetch,
                  input last, output ready);
endinterface

@@ rtl/fscc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fscc_ctrl
// Sequencer for lookup scan, clock sweep, miss fill and flush walk.
// ----------------------------------------------------------------------------
module fscc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [fscc_pkg::FUNC_W-1:0] in_func,
  output logic                       in_ready,
  input  fscc_pkg::fscc_sts_t        sts,
  output fscc_pkg::fscc_cmd_t        cmd
);
  import fscc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_HIT    = 3'd2;
  localparam logic [2:0] ST_SWEEP  = 3'd3;
  localparam logic [2:0] ST_MISS   = 3'd4;
  localparam logic [2:0] ST_FSCAN  = 3'd5;
  localparam logic [2:0] ST_FEMIT  = 3'd6;
  localparam logic [2:0] ST_FIDLE  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_item  = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.fcnt_clr = 1'b1;
          case (in_func)
            FUNC_READ, FUNC_WRITE: state_nxt = ST_LOOKUP;
            FUNC_FLUSH:            state_nxt = ST_FSCAN;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (sts.hit_match) begin
          state_nxt = ST_HIT;
        end else if (sts.idx_last) begin
          state_nxt = ST_SWEEP;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_HIT: begin
        if (sts.out_free) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (!sts.ref_at_hand) begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        if (sts.out_free) begin
          cmd.emit_miss = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FSCAN: begin
        if (sts.vd_at_idx) begin
          state_nxt = ST_FEMIT;
        end else if (sts.idx_last) begin
          state_nxt = sts.fcnt_zero ? ST_FIDLE : ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_FEMIT: begin
        if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          if (sts.flush_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_FSCAN;
          end
        end
      end
      ST_FIDLE: begin
        if (sts.out_free) begin
          cmd.emit_idle = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_item |-> (state_r == ST_IDLE))
    else $error("item loaded outside idle");
`endif

endmodule

@@ rtl/fscc_dp.sv @@
// ----------------------------------------------------------------------------
// fscc_dp
// Tag memory, slot flags, clock hand, scan index and result register.
// ----------------------------------------------------------------------------
module fscc_dp #(
  parameter int SLOTS = fscc_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fscc_pkg::fscc_cmd_t          cmd,
  output fscc_pkg::fscc_sts_t          sts,
  input  logic [fscc_pkg::FUNC_W-1:0]   in_func,
  input  logic [fscc_pkg::SECTOR_W-1:0] in_sector,
  input  logic                         cfg_wr_en,
  input  logic [fscc_pkg::SECTOR_W-1:0] cfg_wr_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output fscc_pkg::fscc_result_t       out_res
);
  import fscc_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SLOTS - 1);

  logic [SECTOR_W-1:0] tag_mem [SLOTS];
  logic [SECTOR_W-1:0] rd_data_r;

  logic [SECTOR_W-1:0] cfg_offset_r;
  logic [FUNC_W-1:0]   func_r;
  logic [SECTOR_W-1:0] sector_r;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] ref_r, ref_nxt;
  logic [SLOTS-1:0] dirty_r, dirty_nxt;
  logic [IDX_W-1:0] hand_r, hand_nxt, hand_inc;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;

  logic [SLOTS-1:0] vd;
  logic [SLOTS-1:0] above;
  logic             more_above;
  logic             emit_any;

  logic         out_valid_r;
  fscc_result_t res_r, res_nxt;

  assign vd       = valid_r & dirty_r;
  assign hand_inc = (hand_r == IDX_MAX) ? '0 : hand_r + 1'b1;
  assign emit_any = cmd.emit_hit | cmd.emit_miss | cmd.emit_flush | cmd.emit_idle;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (IDX_W'(j) > idx_r);
    end
  end
  assign more_above = |(vd & above);

  assign sts.hit_match   = valid_r[idx_r] && (rd_data_r == sector_r);
  assign sts.idx_last    = (idx_r == IDX_MAX);
  assign sts.ref_at_hand = ref_r[hand_r];
  assign sts.vd_at_idx   = vd[idx_r];
  assign sts.flush_last  = (fcnt_r == FCNT_W'(MAX_RESULTS - 1)) || !more_above;
  assign sts.fcnt_zero   = (fcnt_r == '0);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    idx_nxt   = idx_r;
    hand_nxt  = hand_r;
    fcnt_nxt  = fcnt_r;
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    dirty_nxt = dirty_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.fcnt_clr) begin
      fcnt_nxt = '0;
    end
    if (cmd.sweep_step) begin
      hand_nxt = hand_inc;
      if (ref_r[hand_r]) begin
        ref_nxt[hand_r] = 1'b0;
      end else begin
        idx_nxt = hand_r;
      end
    end
    if (cmd.emit_hit) begin
      ref_nxt[idx_r] = 1'b1;
      if (func_r == FUNC_WRITE) begin
        dirty_nxt[idx_r] = 1'b1;
      end
    end
    if (cmd.emit_miss) begin
      valid_nxt[idx_r] = 1'b1;
      ref_nxt[idx_r]   = 1'b1;
      dirty_nxt[idx_r] = (func_r == FUNC_WRITE);
    end
    if (cmd.emit_flush) begin
      dirty_nxt[idx_r] = 1'b0;
      fcnt_nxt         = fcnt_r + 1'b1;
    end
  end

  always_comb begin
    res_nxt      = '0;
    res_nxt.slot = SLOT_W'(idx_r);
    res_nxt.last = 1'b1;
    if (cmd.emit_hit) begin
      res_nxt.hit = 1'b1;
    end else if (cmd.emit_miss) begin
      res_nxt.fetch      = 1'b1;
      res_nxt.write_back = vd[idx_r];
    end else if (cmd.emit_flush) begin
      res_nxt.write_back = 1'b1;
      res_nxt.last       = sts.flush_last;
    end else begin
      res_nxt.slot = '0;
    end
    if (res_nxt.write_back) begin
      res_nxt.write_sector  = rd_data_r;
      res_nxt.mirror_sector = rd_data_r + cfg_offset_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_miss) begin
      tag_mem[idx_r] <= sector_r;
    end
    rd_data_r <= tag_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      func_r   <= in_func;
      sector_r <= in_sector;
    end
    if (emit_any) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_offset_r <= '0;
      valid_r      <= '0;
      ref_r        <= '0;
      dirty_r      <= '0;
      hand_r       <= '0;
      idx_r        <= '0;
      fcnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_offset_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
      dirty_r <= dirty_nxt;
      hand_r  <= hand_nxt;
      idx_r   <= idx_nxt;
      fcnt_r  <= fcnt_nxt;
      if (emit_any) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`ifndef ASSERT_OFF
  a_emit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_hit, cmd.emit_miss, cmd.emit_flush, cmd.emit_idle}))
    else $error("more than one result source in a cycle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_any |-> (!out_valid_r || out_ready))
    else $error("pending word overwritten");
  a_fill_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_miss |=> (valid_r[$past(idx_r)] && ref_r[$past(idx_r)]))
    else $error("filled slot not valid and referenced");
  a_flush_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_flush |-> vd[idx_r])
    else $error("flush of a clean slot");
`endif

endmodule

@@ rtl/fat_sector_clock_cache.sv @@
// ----------------------------------------------------------------------------
// fat_sector_clock_cache
// Write-back sector buffer cache with clock replacement and mirrored FAT
// write-back reporting.
// ----------------------------------------------------------------------------
// Read and write accesses scan the tag memory one slot per cycle from slot 0.
// A miss scans all SLOTS slots, then runs the clock sweep over the reference
// bits, one slot per cycle and at most SLOTS+1 steps, then emits the miss
// result. A flush walks the slots upward and reports each dirty slot, at most
// eight dirty slots, lowest first, or one idle word when no slot is dirty. A
// new word is taken once the sequencer is back in idle; the result register
// holds the previous word until the sink takes it. Function code 3 is accepted
// and dropped without a result.
module fat_sector_clock_cache #(
  parameter int SLOTS = fscc_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fscc_in_if.sink                       in_ch,
  fscc_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [fscc_pkg::SECTOR_W-1:0] cfg_wr_data
);
  import fscc_pkg::*;

  fscc_cmd_t    cmd;
  fscc_sts_t    sts;
  fscc_result_t res;

  fscc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fscc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_func     (in_ch.func),
    .in_sector   (in_ch.sector),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_res     (res)
  );

  assign out_ch.slot          = res.slot;
  assign out_ch.hit           = res.hit;
  assign out_ch.write_back    = res.write_back;
  assign out_ch.write_sector  = res.write_sector;
  assign out_ch.mirror_sector = res.mirror_sector;
  assign out_ch.fetch         = res.fetch;
  assign out_ch.last          = res.last;

endmodule
